[rtl/ice_pkg.sv]
package ice_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned WordW = 16;

    typedef struct packed {
        logic [WordW-1:0] checksum_value;
        logic             mismatch;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_result_beat;

    function automatic logic [WordW-1:0] add_end_around(
        input logic [WordW-1:0] a,
        input logic [WordW-1:0] b
    );
        logic [WordW:0] t;
        logic [WordW:0] u;
        t = {1'b0, a} + {1'b0, b};
        u = {1'b0, t[WordW-1:0]} + {{WordW{1'b0}}, t[WordW]};
        return u[WordW-1:0];
    endfunction

endpackage

[rtl/ice_accum.sv]
module ice_accum
    import ice_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [ByteW-1:0] i_data_byte,
    input  logic             i_is_check_field,
    input  logic             i_is_last,
    output t_result_beat     o_result
);

    logic [WordW-1:0] r_running_sum;
    logic [WordW-1:0] n_running_sum;
    logic             r_odd_phase;
    logic             n_odd_phase;
    logic [ByteW-1:0] r_held_high_byte;
    logic [ByteW-1:0] n_held_high_byte;
    logic [WordW-1:0] r_captured_check;
    logic [WordW-1:0] n_captured_check;

    logic [ByteW-1:0] eff;
    logic [WordW-1:0] sum_upd;
    logic [WordW-1:0] csum;

    always_comb begin
        eff              = i_is_check_field ? '0 : i_data_byte;
        n_captured_check = r_captured_check;
        n_odd_phase      = r_odd_phase;
        n_held_high_byte = r_held_high_byte;
        sum_upd          = r_running_sum;
        if (i_is_check_field) begin
            n_captured_check = {r_captured_check[ByteW-1:0], i_data_byte};
        end
        if (r_odd_phase) begin
            sum_upd          = add_end_around(r_running_sum, {r_held_high_byte, eff});
            n_odd_phase      = 1'b0;
            n_held_high_byte = '0;
        end else if (i_is_last) begin
            sum_upd = add_end_around(r_running_sum, {eff, {ByteW{1'b0}}});
        end else begin
            n_held_high_byte = eff;
            n_odd_phase      = 1'b1;
        end
        csum          = ~sum_upd;
        n_running_sum = sum_upd;

        o_result.valid               = i_fire && i_is_last;
        o_result.data.checksum_value = csum;
        o_result.data.mismatch       = (n_captured_check != csum);

        if (i_is_last) begin
            n_running_sum    = '0;
            n_odd_phase      = 1'b0;
            n_held_high_byte = '0;
            n_captured_check = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_sum    <= '0;
            r_odd_phase      <= 1'b0;
            r_held_high_byte <= '0;
            r_captured_check <= '0;
        end else if (i_fire) begin
            r_running_sum    <= n_running_sum;
            r_odd_phase      <= n_odd_phase;
            r_held_high_byte <= n_held_high_byte;
            r_captured_check <= n_captured_check;
        end
    end

endmodule

[rtl/ice_out_reg.sv]
module ice_out_reg
    import ice_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_result_beat i_result,
    input  logic         i_m_tready,
    output logic         o_can_load,
    output logic         o_m_tvalid,
    output t_result      o_data
);

    logic    r_valid;
    t_result r_data;

    assign o_can_load = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_data     = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_result.valid) begin
            r_data <= i_result.data;
        end
    end

endmodule

[rtl/internet_checksum_engine_unit.sv]
// Internet checksum engine: ones' complement sum over a byte stream.
// Input channel (s side): one byte per beat in wire order. tdata carries the
// byte, tuser flags a byte of the stored checksum field (summed as zero and
// captured), and tlast marks the final byte of the covered region.
// Output channel (m side): one beat per region, sent after its last byte.
// tdata carries the complemented 16-bit sum with the first wire byte in the
// upper half; tuser is set when the captured field differs from that sum.
// Throughput is one byte per cycle while tready is high: the word add with
// end-around carry and the final compare complete in the cycle the byte is
// accepted. The result beat sits in a single output register and appears
// in the cycle after the last byte is accepted.
// Reset clears the running sum, byte phase, captured field and the output
// valid flag; accumulation resumes with a high byte.
// When the receiver stalls, input is still taken until a result waits in
// the output register; tready then drops until that result is taken.
module internet_checksum_engine_unit
    import ice_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [ByteW-1:0] i_s_tdata,  // [7:0] data_byte
    input  logic             i_s_tuser,  // [0] is_check_field
    input  logic             i_s_tlast,  // is_last
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [WordW-1:0] o_m_tdata,  // [15:0] checksum_value
    output logic             o_m_tuser   // [0] mismatch
);

    logic         fire;
    logic         can_load;
    t_result_beat result;
    t_result      out_data;

    assign o_s_tready = can_load;
    assign fire       = i_s_tvalid && can_load;

    ice_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_data_byte      (i_s_tdata),
        .i_is_check_field (i_s_tuser),
        .i_is_last        (i_s_tlast),
        .o_result         (result)
    );

    ice_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_result   (result),
        .i_m_tready (i_m_tready),
        .o_can_load (can_load),
        .o_m_tvalid (o_m_tvalid),
        .o_data     (out_data)
    );

    assign o_m_tdata = out_data.checksum_value;
    assign o_m_tuser = out_data.mismatch;

endmodule

[rtl/ice_checker.sv]
module ice_checker
    import ice_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_tvalid,
    input logic             o_s_tready,
    input logic             i_s_tlast,
    input logic             o_m_tvalid,
    input logic             i_m_tready,
    input logic [WordW-1:0] o_m_tdata,
    input logic             o_m_tuser
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output beat valid right after reset");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tlast |=> o_m_tvalid)
        else $error("no result beat after the last input byte");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid ##1 o_m_tvalid |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("result beat without a last input byte");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while the output register is empty");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result beat changed");

endmodule

bind internet_checksum_engine_unit ice_checker u_ice_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

[sim/tb.sv]
module tb;
    import ice_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;
    localparam int HoldAtBytes = 300;
    localparam int HoldCycles = 300;
    localparam int PhaseBytes = 180;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             flag;
        logic             last;
    } t_wire_byte;

    typedef struct packed {
        logic [WordW-1:0] sum;
        logic             odd;
        logic [ByteW-1:0] held;
        logic [WordW-1:0] captured;
    } t_sum_state;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [ByteW-1:0] i_s_tdata = '0;  // [7:0] data_byte
    logic             i_s_tuser = 1'b0;  // [0] is_check_field
    logic             i_s_tlast = 1'b0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [WordW-1:0] o_m_tdata;  // [15:0] checksum_value
    logic             o_m_tuser;  // [0] mismatch

    t_wire_byte pending_bytes[$];
    t_result    expected_sums[$];
    t_sum_state sum_state = '0;

    logic byte_taken = 1'b0;
    logic src_idle = 1'b0;
    logic sink_idle = 1'b0;
    logic hold_done = 1'b0;
    int   bytes_in = 0;
    int   sums_checked = 0;
    int   sums_flagged = 0;
    int   regions_sent = 0;
    int   err_count = 0;
    int   cycle_count = 0;

    internet_checksum_engine_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_sum_state absorb_byte(
        input t_sum_state       s,
        input logic [ByteW-1:0] b,
        input logic             flag,
        input logic             last
    );
        logic [ByteW-1:0] eff;
        logic [WordW:0]   t;
        eff = flag ? '0 : b;
        if (flag) begin
            s.captured = {s.captured[ByteW-1:0], b};
        end
        if (s.odd) begin
            t = {1'b0, s.sum} + {1'b0, s.held, eff};
            s.odd = 1'b0;
            s.held = '0;
        end else if (last) begin
            t = {1'b0, s.sum} + {1'b0, eff, 8'h00};
        end else begin
            t = {1'b0, s.sum};
            s.held = eff;
            s.odd = 1'b1;
        end
        s.sum = t[WordW-1:0] + {{(WordW-1){1'b0}}, t[WordW]};
        return s;
    endfunction

    function automatic t_result close_region(input t_sum_state s);
        t_result r;
        r.checksum_value = ~s.sum;
        r.mismatch = (s.captured != r.checksum_value);
        return r;
    endfunction

    function automatic int pick_gap(input logic enabled, input int idle_pct);
        int r;
        if (!enabled) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r >= idle_pct) begin
            return 0;
        end else if (r >= idle_pct / 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ByteW-1:0] pick_data(input int fill);
        case (fill)
            1: begin
                return 8'hff;
            end
            2: begin
                return 8'h00;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic push_byte(input logic [ByteW-1:0] b, input logic flag, input logic last);
        t_wire_byte w;
        w.data = b;
        w.flag = flag;
        w.last = last;
        pending_bytes.push_back(w);
        if (last) begin
            regions_sent++;
        end
    endtask

    task automatic push_region(input int len, input int kind);
        t_wire_byte region[$];
        t_wire_byte w;
        t_sum_state s;
        t_result res;
        logic [WordW-1:0] stored;
        int fill;
        int pos;
        int r;
        r = $urandom_range(0, 99);
        fill = (r < 80) ? 0 : (r < 92) ? 1 : 2;
        for (int i = 0; i < len; i++) begin
            w.data = pick_data(fill);
            w.flag = (kind == 2) ? ($urandom_range(0, 3) == 0) : 1'b0;
            w.last = (i == len - 1);
            region.push_back(w);
        end
        if (kind == 1 && len >= 2) begin
            pos = 2 * $urandom_range(0, (len - 2) / 2);
            region[pos].flag = 1'b1;
            region[pos + 1].flag = 1'b1;
            s = '0;
            foreach (region[i]) begin
                s = absorb_byte(s, region[i].data, region[i].flag, region[i].last);
            end
            res = close_region(s);
            stored = res.checksum_value;
            if ($urandom_range(0, 3) == 0) begin
                stored ^= 16'(1) << $urandom_range(0, WordW - 1);
            end
            region[pos].data = stored[15:8];
            region[pos + 1].data = stored[7:0];
        end
        foreach (region[i]) begin
            push_byte(region[i].data, region[i].flag, region[i].last);
        end
    endtask

    always @(negedge i_clk) begin
        int src_gap;
        t_wire_byte w;
        if (!i_s_tvalid || byte_taken) begin
            if (src_gap > 0) begin
                src_gap--;
                i_s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                w = pending_bytes.pop_front();
                i_s_tdata <= w.data;
                i_s_tuser <= w.flag;
                i_s_tlast <= w.last;
                i_s_tvalid <= 1'b1;
                src_gap = pick_gap(src_idle, 30);
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int sink_wait;
        if (sink_wait == 0) begin
            if (!hold_done && bytes_in >= HoldAtBytes) begin
                sink_wait = HoldCycles;
                hold_done = 1'b1;
            end else begin
                sink_wait = pick_gap(sink_idle, 25);
            end
        end
        if (sink_wait > 0) begin
            sink_wait--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Input beats update the predicted state before the output beat of the same edge is checked.
    always @(posedge i_clk) begin
        t_result want;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                byte_taken = 1'b1;
                bytes_in++;
                sum_state = absorb_byte(sum_state, i_s_tdata, i_s_tuser, i_s_tlast);
                if (i_s_tlast) begin
                    expected_sums.push_back(close_region(sum_state));
                    sum_state = '0;
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_sums.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result beat sum=%h mismatch=%b",
                             $time, o_m_tdata, o_m_tuser);
                end else begin
                    want = expected_sums.pop_front();
                    sums_checked++;
                    if (o_m_tuser) begin
                        sums_flagged++;
                    end
                    if (o_m_tdata !== want.checksum_value) begin
                        err_count++;
                        $display("%0t: checksum_value expected %h actual %h",
                                 $time, want.checksum_value, o_m_tdata);
                    end
                    if (o_m_tuser !== want.mismatch) begin
                        err_count++;
                        $display("%0t: mismatch expected %b actual %b",
                                 $time, want.mismatch, o_m_tuser);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_sums.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        int phase_start;
        int r;
        int len;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hff, 1'b0, 1'b1);
        repeat (3) push_byte(8'hff, 1'b0, 1'b0);
        push_byte(8'hff, 1'b0, 1'b1);
        push_byte(8'h45, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'ha8, 1'b1, 1'b0);
        push_byte(8'hcb, 1'b1, 1'b0);
        push_byte(8'h12, 1'b0, 1'b0);
        push_byte(8'h34, 1'b0, 1'b1);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'hff, 1'b1, 1'b0);
        push_byte(8'h02, 1'b0, 1'b1);
        push_byte(8'h11, 1'b1, 1'b0);
        push_byte(8'h22, 1'b1, 1'b0);
        push_byte(8'h33, 1'b1, 1'b0);
        push_byte(8'h44, 1'b0, 1'b1);
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'h66, 1'b1, 1'b1);
        push_byte(8'h80, 1'b1, 1'b1);
        push_byte(8'h7f, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b1);
        while (pending_bytes.size() > 0 || expected_sums.size() > 0) @(posedge i_clk);

        for (int phase = 0; phase < 4; phase++) begin
            src_idle = (phase == 0 || phase == 2);
            sink_idle = (phase == 0 || phase == 3);
            phase_start = pending_bytes.size();
            while (pending_bytes.size() - phase_start < PhaseBytes) begin
                r = $urandom_range(0, 99);
                len = (r < 85) ? $urandom_range(1, 12) :
                      (r < 97) ? $urandom_range(13, 40) : $urandom_range(60, 120);
                r = $urandom_range(0, 99);
                push_region(len, (r < 45) ? 1 : (r < 75) ? 0 : 2);
            end
            while (pending_bytes.size() > 0) @(posedge i_clk);
        end

        while (i_s_tvalid || expected_sums.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d bytes in %0d regions fed, %0d checksum beats compared (%0d flagged).",
                 bytes_in, regions_sent, sums_checked, sums_flagged);
        $display("Phases ran with and without idling on both sides, with one long output hold.");
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
